// ----- src/tms_pkg.sv -----
// ----------------------------------------------------------------------------
// tms_pkg: shared types and constants of the timed mission sequencer
// Mission states, drive and claw codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package tms_pkg;

  // Width of one configuration register as seen by software
  localparam int CFG_W    = 16;
  localparam int NUM_REGS = 8;
  localparam int IDX_W    = 3;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_INIT_TIMEOUT = 3'd0;
  localparam logic [IDX_W-1:0] REG_LINE_LOSS    = 3'd1;
  localparam logic [IDX_W-1:0] REG_DRIVE_PHASE  = 3'd2;
  localparam logic [IDX_W-1:0] REG_CLOSE_PHASE  = 3'd3;
  localparam logic [IDX_W-1:0] REG_ROTATE_PHASE = 3'd4;
  localparam logic [IDX_W-1:0] REG_SPIN         = 3'd5;
  localparam logic [IDX_W-1:0] REG_RETURN       = 3'd6;
  localparam logic [IDX_W-1:0] REG_DROP         = 3'd7;

  localparam logic [CFG_W-1:0] CFG_RESET [NUM_REGS] = '{
    16'd500, 16'd50, 16'd50, 16'd50, 16'd50, 16'd100, 16'd500, 16'd50
  };

  // Mission state, one-hot
  typedef enum logic [7:0] {
    MODE_INIT     = 8'b0000_0001,
    MODE_SEARCH   = 8'b0000_0010,
    MODE_PICKUP   = 8'b0000_0100,
    MODE_SPIN     = 8'b0000_1000,
    MODE_RETURN   = 8'b0001_0000,
    MODE_DROP     = 8'b0010_0000,
    MODE_DONE     = 8'b0100_0000,
    MODE_FAILSAFE = 8'b1000_0000
  } mode_e;

  // Mission state as reported on the result channel
  localparam logic [2:0] CODE_INIT     = 3'd0;
  localparam logic [2:0] CODE_SEARCH   = 3'd1;
  localparam logic [2:0] CODE_PICKUP   = 3'd2;
  localparam logic [2:0] CODE_SPIN     = 3'd3;
  localparam logic [2:0] CODE_RETURN   = 3'd4;
  localparam logic [2:0] CODE_DROP     = 3'd5;
  localparam logic [2:0] CODE_DONE     = 3'd6;
  localparam logic [2:0] CODE_FAILSAFE = 3'd7;

  typedef enum logic [1:0] {
    DRV_STOP = 2'd0,
    DRV_LINE = 2'd1,
    DRV_FWD  = 2'd2,
    DRV_SPIN = 2'd3
  } drv_e;

  typedef enum logic [2:0] {
    CLAW_NONE   = 3'd0,
    CLAW_CLOSE  = 3'd1,
    CLAW_ROTATE = 3'd2,
    CLAW_HOLD   = 3'd3,
    CLAW_OPEN   = 3'd4
  } claw_e;

  // One control tick
  typedef struct packed {
    logic line_ok;
    logic target_seen;
    logic motor_rdy;
    logic estop;
  } tms_tick_t;

  // One result beat
  typedef struct packed {
    logic [2:0] mission_state;
    drv_e       drive_mode;
    claw_e      claw_cmd;
    logic       claw_write;
    logic       detect_enable;
  } tms_res_t;

  function automatic logic [2:0] mode_code(mode_e m);
    logic [2:0] c;
    case (m)
      MODE_INIT:     c = CODE_INIT;
      MODE_SEARCH:   c = CODE_SEARCH;
      MODE_PICKUP:   c = CODE_PICKUP;
      MODE_SPIN:     c = CODE_SPIN;
      MODE_RETURN:   c = CODE_RETURN;
      MODE_DROP:     c = CODE_DROP;
      MODE_DONE:     c = CODE_DONE;
      default:       c = CODE_FAILSAFE;
    endcase
    return c;
  endfunction

endpackage

// ----- src/tms_if.sv -----
// ----------------------------------------------------------------------------
// tms_if: tick and result channels of the timed mission sequencer
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface tms_in_if;
  logic valid;
  logic ready;
  logic line_ok;
  logic target_seen;
  logic motor_rdy;
  logic estop;

  modport source (output valid, line_ok, target_seen, motor_rdy, estop, input ready);
  modport sink   (input valid, line_ok, target_seen, motor_rdy, estop, output ready);
endinterface

interface tms_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] mission_state;
  logic [1:0] drive_mode;
  logic [2:0] claw_cmd;
  logic       claw_write;
  logic       detect_enable;

  modport source (output valid, mission_state, drive_mode, claw_cmd, claw_write,
                  detect_enable, input ready);
  modport sink   (input valid, mission_state, drive_mode, claw_cmd, claw_write,
                  detect_enable, output ready);
endinterface

// ----- src/timed_mission_sequencer.sv -----
// ----------------------------------------------------------------------------
// timed_mission_sequencer: pick-and-place mission controller
// Steps a timed mission one control tick per input beat.
// ----------------------------------------------------------------------------
// Usage
//   in_i  (sink)   : one beat per control tick: line_ok, target_seen,
//                    motor_rdy, estop.
//   out_o (source) : one beat per tick with the mission state, drive mode,
//                    claw command, claw write strobe and detection enable,
//                    all as they stand after that tick.
//   cfg_*          : write-only timing registers (tick counts), indexes 0..7;
//                    write them only while no tick is in flight.
// Path: a tick is registered in the tick register on acceptance and stepped
//   from there straight into the output register, which holds the result
//   beat; a stall at the output can hold the tick in the tick register.
// Throughput: one tick per cycle while the receiver keeps ready high; the step is a
//   single pass of compares and counter updates between the tick register and the result register.
// Reset: mission back in init, counters and line-seen flag cleared, drive
//   stop, no claw command, detection enabled, registers at their defaults.
// Stall: while the receiver holds ready low the result is held; a further tick
//   is still taken only if the tick register is empty, then ready drops.
// ----------------------------------------------------------------------------
module timed_mission_sequencer #(
  parameter int ELAPSED_BITS = 18,
  parameter int TIMEOUT_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  tms_in_if.sink                    in_i,
  tms_out_if.source                 out_o,
  input  logic                      cfg_we_i,
  input  logic [tms_pkg::IDX_W-1:0] cfg_idx_i,
  input  logic [TIMEOUT_BITS-1:0]   cfg_wdata_i
);

  localparam int RegW = (TIMEOUT_BITS > tms_pkg::CFG_W) ? TIMEOUT_BITS : tms_pkg::CFG_W;

  // Timing registers
  logic [RegW-1:0] regs [tms_pkg::NUM_REGS];

  tms_cfg_regs #(
    .TIMEOUT_BITS (TIMEOUT_BITS)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .regs_o      (regs)
  );

  // Tick register and pipeline control
  logic               tick_v_q;
  tms_pkg::tms_tick_t tick_q;
  logic               out_v_q;
  tms_pkg::tms_res_t  out_q;
  logic               advance;
  logic               step_fire;
  logic               in_fire;

  // advance whenever the result register is empty or being drained
  assign advance   = !out_v_q || out_o.ready;
  assign step_fire = tick_v_q && advance;
  assign in_i.ready = !tick_v_q || advance;
  assign in_fire   = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_v_q <= 1'b0;
    end else if (in_i.ready) begin
      tick_v_q <= in_i.valid;
    end
  end

  // Payload loads only when the beat is taken
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      tick_q.line_ok     <= in_i.line_ok;
      tick_q.target_seen <= in_i.target_seen;
      tick_q.motor_rdy   <= in_i.motor_rdy;
      tick_q.estop       <= in_i.estop;
    end
  end

  // Mission state
  tms_pkg::mode_e          mode_q,  mode_d;
  logic [ELAPSED_BITS-1:0] elapsed_q, elapsed_d;
  logic [TIMEOUT_BITS:0]   loss_q,  loss_d;
  logic                    seen_q,  seen_d;
  tms_pkg::drv_e           drive_q;
  tms_pkg::claw_e          claw_q;
  logic                    detect_q;
  tms_pkg::tms_res_t       res_d;

  tms_step #(
    .ELAPSED_BITS (ELAPSED_BITS),
    .TIMEOUT_BITS (TIMEOUT_BITS)
  ) u_step (
    .tick_i    (tick_q),
    .mode_i    (mode_q),
    .elapsed_i (elapsed_q),
    .loss_i    (loss_q),
    .seen_i    (seen_q),
    .drive_i   (drive_q),
    .claw_i    (claw_q),
    .detect_i  (detect_q),
    .regs_i    (regs),
    .mode_o    (mode_d),
    .elapsed_o (elapsed_d),
    .loss_o    (loss_d),
    .seen_o    (seen_d),
    .res_o     (res_d)
  );

  // Commit the step and load the result register together
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= tms_pkg::MODE_INIT;
      elapsed_q <= '0;
      loss_q    <= '0;
      seen_q    <= 1'b0;
      drive_q   <= tms_pkg::DRV_STOP;
      claw_q    <= tms_pkg::CLAW_NONE;
      detect_q  <= 1'b1;
    end else if (step_fire) begin
      mode_q    <= mode_d;
      elapsed_q <= elapsed_d;
      loss_q    <= loss_d;
      seen_q    <= seen_d;
      drive_q   <= res_d.drive_mode;
      claw_q    <= res_d.claw_cmd;
      detect_q  <= res_d.detect_enable;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (advance) begin
      out_v_q <= tick_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_fire) begin
      out_q <= res_d;
    end
  end

  assign out_o.valid         = out_v_q;
  assign out_o.mission_state = out_q.mission_state;
  assign out_o.drive_mode    = out_q.drive_mode;
  assign out_o.claw_cmd      = out_q.claw_cmd;
  assign out_o.claw_write    = out_q.claw_write;
  assign out_o.detect_enable = out_q.detect_enable;

`ifndef SYNTH
  // A stepped tick always lands in the result register
  a_step_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_fire |=> out_v_q)
    else $error("stepped tick produced no result beat");

  // Failsafe is terminal
  a_failsafe_terminal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == tms_pkg::MODE_FAILSAFE) |=> (mode_q == tms_pkg::MODE_FAILSAFE))
    else $error("left failsafe");

  // A claw command always names a claw mode
  a_claw_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_q.claw_write) |-> (out_q.claw_cmd != tms_pkg::CLAW_NONE))
    else $error("claw write without claw mode");

  // The reported state matches the committed state once the pipe is drained
  a_state_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !tick_v_q) |-> (out_q.mission_state == tms_pkg::mode_code(mode_q)))
    else $error("reported state differs from mission state");
`endif

endmodule

// ----- src/tms_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// tms_cfg_regs: timing register file
// Eight tick-count registers, written through a plain write port.
// ----------------------------------------------------------------------------
module tms_cfg_regs #(
  parameter int TIMEOUT_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tms_pkg::IDX_W-1:0]    cfg_idx_i,
  input  logic [TIMEOUT_BITS-1:0]      cfg_wdata_i,
  output logic [((TIMEOUT_BITS > tms_pkg::CFG_W) ? TIMEOUT_BITS : tms_pkg::CFG_W)-1:0]
                                       regs_o [tms_pkg::NUM_REGS]
);

  localparam int RegW = (TIMEOUT_BITS > tms_pkg::CFG_W) ? TIMEOUT_BITS : tms_pkg::CFG_W;

  logic [RegW-1:0] regs_q [tms_pkg::NUM_REGS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < tms_pkg::NUM_REGS; i++) begin
        regs_q[i] <= RegW'(tms_pkg::CFG_RESET[i]);
      end
    end else if (cfg_we_i) begin
      regs_q[cfg_idx_i] <= RegW'(cfg_wdata_i);
    end
  end

  assign regs_o = regs_q;

endmodule

// ----- src/tms_step.sv -----
// ----------------------------------------------------------------------------
// tms_step: next-state logic of the mission sequencer
// Works out one tick: counters, failsafe checks and the state handler.
// ----------------------------------------------------------------------------
module tms_step #(
  parameter int ELAPSED_BITS = 18,
  parameter int TIMEOUT_BITS = 16
) (
  input  tms_pkg::tms_tick_t        tick_i,
  input  tms_pkg::mode_e            mode_i,
  input  logic [ELAPSED_BITS-1:0]   elapsed_i,
  input  logic [TIMEOUT_BITS:0]     loss_i,
  input  logic                      seen_i,
  input  tms_pkg::drv_e             drive_i,
  input  tms_pkg::claw_e            claw_i,
  input  logic                      detect_i,
  input  logic [((TIMEOUT_BITS > tms_pkg::CFG_W) ? TIMEOUT_BITS : tms_pkg::CFG_W)-1:0]
                                    regs_i [tms_pkg::NUM_REGS],
  output tms_pkg::mode_e            mode_o,
  output logic [ELAPSED_BITS-1:0]   elapsed_o,
  output logic [TIMEOUT_BITS:0]     loss_o,
  output logic                      seen_o,
  output tms_pkg::tms_res_t         res_o
);

  localparam int RegW  = (TIMEOUT_BITS > tms_pkg::CFG_W) ? TIMEOUT_BITS : tms_pkg::CFG_W;
  localparam int LossW = TIMEOUT_BITS + 1;
  localparam int CmpW  = (ELAPSED_BITS > RegW + 2) ? ELAPSED_BITS : RegW + 2;
  localparam int LcW   = (LossW > RegW) ? LossW : RegW;

  localparam logic [ELAPSED_BITS-1:0] ElMax   = '1;
  localparam logic [LossW-1:0]        LossMax = '1;

  tms_pkg::mode_e          mode_a;
  tms_pkg::mode_e          mode_n;
  logic [ELAPSED_BITS-1:0] el_n;
  logic [LossW-1:0]        loss_n;
  logic                    seen_n;
  logic [CmpW-1:0]         t;
  logic [CmpW-1:0]         p1;
  logic [CmpW-1:0]         p2;
  logic [CmpW-1:0]         p3;
  logic                    loss_over;
  tms_pkg::drv_e           drive_n;
  tms_pkg::claw_e          claw_n;
  logic                    sent_n;
  logic                    det_n;

  assign p1 = CmpW'(regs_i[tms_pkg::REG_DRIVE_PHASE]);
  assign p2 = p1 + CmpW'(regs_i[tms_pkg::REG_CLOSE_PHASE]);
  assign p3 = p2 + CmpW'(regs_i[tms_pkg::REG_ROTATE_PHASE]);

  always_comb begin
    // advance both counters, holding at their maximum; the loss counter clears on line_ok
    el_n   = (elapsed_i == ElMax) ? elapsed_i : elapsed_i + 1'b1;
    if (tick_i.line_ok) begin
      loss_n = '0;
    end else begin
      loss_n = (loss_i == LossMax) ? loss_i : loss_i + 1'b1;
    end
    seen_n = seen_i | tick_i.line_ok;
    mode_a = mode_i;

    if (tick_i.estop && (mode_i != tms_pkg::MODE_FAILSAFE)) begin
      mode_a = tms_pkg::MODE_FAILSAFE;
      el_n   = '0;
    end

    loss_over = LcW'(loss_n) > LcW'(regs_i[tms_pkg::REG_LINE_LOSS]);
    if (((mode_a == tms_pkg::MODE_SEARCH) && seen_n) || (mode_a == tms_pkg::MODE_RETURN)) begin
      if (loss_over) begin
        mode_a = tms_pkg::MODE_FAILSAFE;
        el_n   = '0;
      end
    end

    t       = CmpW'(el_n);
    mode_n  = mode_a;
    drive_n = drive_i;
    claw_n  = claw_i;
    det_n   = detect_i;
    sent_n  = 1'b0;

    case (mode_a)
      tms_pkg::MODE_INIT: begin
        drive_n = tms_pkg::DRV_STOP;
        if ((tick_i.line_ok && tick_i.motor_rdy) ||
            (t > CmpW'(regs_i[tms_pkg::REG_INIT_TIMEOUT]))) begin
          mode_n = tms_pkg::MODE_SEARCH;
          loss_n = '0;
          seen_n = 1'b0;
          el_n   = '0;
        end
      end
      tms_pkg::MODE_SEARCH: begin
        drive_n = tms_pkg::DRV_LINE;
        det_n   = 1'b1;
        if (tick_i.target_seen) begin
          det_n  = 1'b0;
          mode_n = tms_pkg::MODE_PICKUP;
          el_n   = '0;
        end
      end
      tms_pkg::MODE_PICKUP: begin
        if (t < p1) begin
          drive_n = tms_pkg::DRV_FWD;
        end else if (t < p2) begin
          drive_n = tms_pkg::DRV_STOP;
          claw_n  = tms_pkg::CLAW_CLOSE;
          sent_n  = 1'b1;
        end else if (t < p3) begin
          claw_n  = tms_pkg::CLAW_ROTATE;
          sent_n  = 1'b1;
        end else begin
          mode_n = tms_pkg::MODE_SPIN;
          loss_n = '0;
          el_n   = '0;
        end
      end
      tms_pkg::MODE_SPIN: begin
        if (t < CmpW'(regs_i[tms_pkg::REG_SPIN])) begin
          drive_n = tms_pkg::DRV_SPIN;
        end else begin
          drive_n = tms_pkg::DRV_STOP;
          mode_n  = tms_pkg::MODE_RETURN;
          loss_n  = '0;
          el_n    = '0;
        end
      end
      tms_pkg::MODE_RETURN: begin
        drive_n = tms_pkg::DRV_LINE;
        claw_n  = tms_pkg::CLAW_HOLD;
        sent_n  = 1'b1;
        if (t > CmpW'(regs_i[tms_pkg::REG_RETURN])) begin
          mode_n = tms_pkg::MODE_DROP;
          el_n   = '0;
        end
      end
      tms_pkg::MODE_DROP: begin
        drive_n = tms_pkg::DRV_STOP;
        claw_n  = tms_pkg::CLAW_OPEN;
        sent_n  = 1'b1;
        if (t > CmpW'(regs_i[tms_pkg::REG_DROP])) begin
          mode_n = tms_pkg::MODE_DONE;
          el_n   = '0;
        end
      end
      tms_pkg::MODE_DONE: begin
        drive_n = tms_pkg::DRV_STOP;
      end
      default: begin
        drive_n = tms_pkg::DRV_STOP;
        claw_n  = tms_pkg::CLAW_OPEN;
        sent_n  = 1'b1;
      end
    endcase
  end

  assign mode_o    = mode_n;
  assign elapsed_o = el_n;
  assign loss_o    = loss_n;
  assign seen_o    = seen_n;

  assign res_o.mission_state = tms_pkg::mode_code(mode_n);
  assign res_o.drive_mode    = drive_n;
  assign res_o.claw_cmd      = claw_n;
  assign res_o.claw_write    = sent_n;
  assign res_o.detect_enable = det_n;

endmodule
